FILE: src/touch_point_rotate_mirror_clamp_core_macros.svh
// ----------------------------------------------------------------------------
// Touch point mapper assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// while reset is low.
// ----------------------------------------------------------------------------
`ifndef TOUCH_POINT_ROTATE_MIRROR_CLAMP_CORE_MACROS_SVH
`define TOUCH_POINT_ROTATE_MIRROR_CLAMP_CORE_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define TPRMC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tprmc assertion failed");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define TPRMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tprmc assertion failed");

`endif

FILE: src/tprmc_pkg.sv
// ----------------------------------------------------------------------------
// Touch point mapper package
// Configuration struct, register and mode codes, and coordinate helpers.
// ----------------------------------------------------------------------------
package tprmc_pkg;

    // Width of signed intermediate coordinates (covers 16-bit raw input,
    // panel offsets up to 4095 and one mirror step without overflow)
    localparam int COORD_W = 19;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_SENSOR_PRESENT = 3'd0;
    localparam logic [2:0] REG_ROTATION       = 3'd1;
    localparam logic [2:0] REG_FLIP_SEL       = 3'd2;
    localparam logic [2:0] REG_VIEW_WIDTH     = 3'd3;
    localparam logic [2:0] REG_VIEW_HEIGHT    = 3'd4;

    // Rotation codes
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    // Mirror mode bits
    localparam int MIRROR_X_BIT = 0;
    localparam int MIRROR_Y_BIT = 1;

    // View size limits
    localparam logic [12:0] VIEW_MAX = 13'd4096;
    localparam logic [12:0] VIEW_MIN = 13'd1;

    typedef struct packed {
        logic        sensor_present;
        logic [1:0]  rotation;
        logic [1:0]  flip_sel;
        logic [12:0] view_width;
        logic [12:0] view_height;
    } cfg_t;

    typedef struct packed {
        logic        pressed;
        logic [11:0] point_x;
        logic [11:0] point_y;
    } map_res_t;

    // Force a view size into 1..4096
    function automatic logic [12:0] eff_size(input logic [12:0] s);
        logic [12:0] r;
        r = s;
        if (s == 13'd0) begin
            r = VIEW_MIN;
        end else if (s > VIEW_MAX) begin
            r = VIEW_MAX;
        end
        return r;
    endfunction

    // Clamp a signed coordinate into 0..size-1
    function automatic logic [11:0] clamp_coord(input logic signed [COORD_W-1:0] v,
                                                input logic [12:0] size);
        logic signed [COORD_W-1:0] size_s;
        logic [12:0]               size_m1;
        logic [11:0]               r;
        size_s  = $signed({{(COORD_W-13){1'b0}}, size});
        size_m1 = size - 13'd1;
        if (v < 0) begin
            r = 12'd0;
        end else if (v >= size_s) begin
            r = size_m1[11:0];
        end else begin
            r = v[11:0];
        end
        return r;
    endfunction

endpackage

FILE: src/touch_point_rotate_mirror_clamp_core.sv
// ----------------------------------------------------------------------------
// Touch point mapper core
// Maps raw touch polls to clamped display coordinates with held state.
// ----------------------------------------------------------------------------
// One result item comes out for every input item. The item lands in an input
// register at its accepting edge, passes the rotate, mirror and clamp logic,
// and is written into the result register once that one is free or being read;
// its result then shows on m_tvalid. The result register also holds
// the last mapped point, the last raw point and the press count. A new item is
// accepted in every cycle while results are taken, since the input register
// empties into the result register whenever that one is free or being read; a
// stalled result holds one item in each register and then drops s_tready. A
// release item (no touch, or sensor_present clear) reports the held state
// unchanged. Write the configuration registers only while no item is in flight.
`include "touch_point_rotate_mirror_clamp_core_macros.svh"

module touch_point_rotate_mirror_clamp_core #(
    parameter int PANEL_WIDTH  = 1024,
    parameter int PANEL_HEIGHT = 768
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] raw_x, [31:16] raw_y
    input  logic        s_tuser,   // [0] touched
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // [11:0] point_x, [23:12] point_y, [39:24] held_raw_x,
                                   // [55:40] held_raw_y, [87:56] press_count
    output logic        m_tuser,   // [0] pressed
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tprmc_pkg::*;

    cfg_t        cfg;
    map_res_t    map_res;

    logic        in_valid_reg;
    logic        in_touched_reg;
    logic [15:0] in_raw_x_reg;
    logic [15:0] in_raw_y_reg;

    logic        out_valid_reg;
    logic        pressed_reg;
    logic [11:0] last_point_x_reg;
    logic [11:0] last_point_y_reg;
    logic [15:0] last_raw_x_reg;
    logic [15:0] last_raw_y_reg;
    logic [31:0] press_count_reg;
    logic [31:0] press_count_next;

    logic        out_load;
    logic        in_load;
    logic        press_load;

    tprmc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tprmc_map #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_map (
        .cfg     (cfg),
        .touched (in_touched_reg),
        .raw_x   (in_raw_x_reg),
        .raw_y   (in_raw_y_reg),
        .res     (map_res)
    );

    // Advance when the result slot is free or being emptied
    assign out_load   = in_valid_reg & (~out_valid_reg | m_tready);
    assign in_load    = s_tvalid & s_tready;
    assign s_tready   = ~in_valid_reg | out_load;
    assign press_load = out_load & map_res.pressed;

    assign press_count_next = press_count_reg + 32'd1;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (in_load) begin
            in_touched_reg <= s_tuser;
            in_raw_x_reg   <= s_tdata[15:0];
            in_raw_y_reg   <= s_tdata[31:16];
        end
    end

    // Result register and held state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg    <= 1'b0;
            pressed_reg      <= 1'b0;
            last_point_x_reg <= 12'd0;
            last_point_y_reg <= 12'd0;
            last_raw_x_reg   <= 16'd0;
            last_raw_y_reg   <= 16'd0;
            press_count_reg  <= 32'd0;
        end else begin
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (out_load) begin
                pressed_reg <= map_res.pressed;
                if (map_res.pressed) begin
                    last_point_x_reg <= map_res.point_x;
                    last_point_y_reg <= map_res.point_y;
                    last_raw_x_reg   <= in_raw_x_reg;
                    last_raw_y_reg   <= in_raw_y_reg;
                    press_count_reg  <= press_count_next;
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = pressed_reg;
    assign m_tdata  = {press_count_reg, last_raw_y_reg, last_raw_x_reg,
                       last_point_y_reg, last_point_x_reg};

    // A press advances the count by exactly one
    `TPRMC_ASSERT_NEXT(a_press_count, aclk, aresetn, press_load, press_count_reg == $past(press_count_next))
    // A release leaves the held state alone
    `TPRMC_ASSERT_NEXT(a_release_hold, aclk, aresetn, out_load && !map_res.pressed, $stable(m_tdata))
    // Input stalls only when both stages hold an item
    `TPRMC_ASSERT_NOW(a_stall_full, aclk, aresetn, !s_tready, in_valid_reg && out_valid_reg)

endmodule

FILE: src/tprmc_regs.sv
// ----------------------------------------------------------------------------
// Touch point mapper register file
// APB-style configuration registers with read back.
// ----------------------------------------------------------------------------
module tprmc_regs (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output tprmc_pkg::cfg_t    cfg
);
    import tprmc_pkg::*;

    cfg_t        cfg_reg;
    logic        wr_en;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    // Write registers on the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sensor_present <= 1'b0;
            cfg_reg.rotation       <= ROT_0;
            cfg_reg.flip_sel       <= 2'd0;
            cfg_reg.view_width     <= 13'd1024;
            cfg_reg.view_height    <= 13'd768;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SENSOR_PRESENT: cfg_reg.sensor_present <= pwdata[0];
                REG_ROTATION:       cfg_reg.rotation       <= pwdata[1:0];
                REG_FLIP_SEL:       cfg_reg.flip_sel       <= pwdata[1:0];
                REG_VIEW_WIDTH:     cfg_reg.view_width     <= pwdata[12:0];
                REG_VIEW_HEIGHT:    cfg_reg.view_height    <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        prdata = 32'd0;
        unique case (reg_idx)
            REG_SENSOR_PRESENT: prdata = {31'd0, cfg_reg.sensor_present};
            REG_ROTATION:       prdata = {30'd0, cfg_reg.rotation};
            REG_FLIP_SEL:       prdata = {30'd0, cfg_reg.flip_sel};
            REG_VIEW_WIDTH:     prdata = {19'd0, cfg_reg.view_width};
            REG_VIEW_HEIGHT:    prdata = {19'd0, cfg_reg.view_height};
            default:            prdata = 32'd0;
        endcase
    end

endmodule

FILE: src/tprmc_map.sv
// ----------------------------------------------------------------------------
// Touch point mapper coordinate path
// Panel turn, display rotation, mirror and clamp for one touch poll.
// ----------------------------------------------------------------------------
module tprmc_map #(
    parameter int PANEL_WIDTH  = 1024,
    parameter int PANEL_HEIGHT = 768
) (
    input  tprmc_pkg::cfg_t     cfg,
    input  logic                touched,
    input  logic [15:0]         raw_x,
    input  logic [15:0]         raw_y,
    output tprmc_pkg::map_res_t res
);
    import tprmc_pkg::*;

    localparam logic signed [COORD_W-1:0] PW_M1 = COORD_W'(PANEL_WIDTH - 1);
    localparam logic signed [COORD_W-1:0] PH_M1 = COORD_W'(PANEL_HEIGHT - 1);

    logic [12:0]               w_eff;
    logic [12:0]               h_eff;
    logic signed [COORD_W-1:0] w_m1;
    logic signed [COORD_W-1:0] h_m1;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] lx;
    logic signed [COORD_W-1:0] ly;
    logic signed [COORD_W-1:0] mx;
    logic signed [COORD_W-1:0] my;

    assign w_eff = eff_size(cfg.view_width);
    assign h_eff = eff_size(cfg.view_height);
    assign w_m1  = $signed({{(COORD_W-13){1'b0}}, w_eff}) - COORD_W'(1);
    assign h_m1  = $signed({{(COORD_W-13){1'b0}}, h_eff}) - COORD_W'(1);

    // Fixed quarter turn from controller to panel axes
    assign px = PW_M1 - $signed({{(COORD_W-16){1'b0}}, raw_y});
    assign py = $signed({{(COORD_W-16){1'b0}}, raw_x});

    // Display rotation
    always_comb begin
        case (cfg.rotation)
            ROT_90: begin
                lx = py;
                ly = PW_M1 - px;
            end
            ROT_180: begin
                lx = PW_M1 - px;
                ly = PH_M1 - py;
            end
            ROT_270: begin
                lx = PH_M1 - py;
                ly = px;
            end
            default: begin
                lx = px;
                ly = py;
            end
        endcase
    end

    // Mirror against the view size
    assign mx = cfg.flip_sel[MIRROR_X_BIT] ? (w_m1 - lx) : lx;
    assign my = cfg.flip_sel[MIRROR_Y_BIT] ? (h_m1 - ly) : ly;

    // Clamp and flag a press
    assign res.pressed = cfg.sensor_present & touched;
    assign res.point_x = clamp_coord(mx, w_eff);
    assign res.point_y = clamp_coord(my, h_eff);

endmodule

FILE: test/touch_point_rotate_mirror_clamp_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Touch point mapper testbench
// Writes register settings over the configuration port and sends touch polls
// with random gaps. Every result item is checked against an in-bench mapper
// that rotates, mirrors and clamps each poll and keeps the held point, the
// held raw point and the press count.
// ----------------------------------------------------------------------------
module testbench;
    import tprmc_pkg::*;

    localparam int PANEL_W       = 1024;
    localparam int PANEL_H       = 768;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 160;
    localparam int DRAIN_CYCLES  = 4;
    localparam int END_CYCLES    = 8;
    localparam int END_WAIT      = 2000;
    localparam int MAX_PRINTS    = 40;
    localparam int DIR_COUNT     = 23;

    // Mirror mode codes built from the package bit positions
    localparam logic [1:0] MIR_NONE = 2'b00;
    localparam logic [1:0] MIR_X    = 2'b01 << MIRROR_X_BIT;
    localparam logic [1:0] MIR_Y    = 2'b01 << MIRROR_Y_BIT;
    localparam logic [1:0] MIR_XY   = MIR_X | MIR_Y;

    typedef struct {
        logic        pressed;
        logic [11:0] point_x;
        logic [11:0] point_y;
        logic [15:0] raw_x;
        logic [15:0] raw_y;
        logic [31:0] presses;
    } touch_result_t;

    // One directed poll with the register setting it runs under
    typedef struct packed {
        logic        present;
        logic [1:0]  rot;
        logic [1:0]  mirror;
        logic [12:0] vw;
        logic [12:0] vh;
        logic        touched;
        logic [15:0] rx;
        logic [15:0] ry;
        logic        known;
        logic        k_pressed;
        logic [11:0] k_x;
        logic [11:0] k_y;
    } poll_row_t;

    localparam poll_row_t DIR_ROWS [DIR_COUNT] = '{
        // release right after reset: sensor not present yet
        '{1'b0, ROT_0, MIR_NONE, 13'd1024, 13'd768, 1'b1, 16'd100, 16'd200,
          1'b1, 1'b0, 12'd0, 12'd0},
        // no touch
        '{1'b1, ROT_0, MIR_NONE, 13'd1024, 13'd768, 1'b0, 16'hFFFF, 16'hFFFF,
          1'b1, 1'b0, 12'd0, 12'd0},
        // raw extremes through each rotation
        '{1'b1, ROT_0, MIR_NONE, 13'd1024, 13'd768, 1'b1, 16'd0, 16'd0,
          1'b1, 1'b1, 12'd1023, 12'd0},
        '{1'b1, ROT_0, MIR_NONE, 13'd1024, 13'd768, 1'b1, 16'hFFFF, 16'hFFFF,
          1'b1, 1'b1, 12'd0, 12'd767},
        '{1'b1, ROT_0, MIR_NONE, 13'd1024, 13'd768, 1'b1, 16'd300, 16'd400,
          1'b1, 1'b1, 12'd623, 12'd300},
        '{1'b1, ROT_90, MIR_NONE, 13'd1024, 13'd768, 1'b1, 16'd0, 16'd0,
          1'b1, 1'b1, 12'd0, 12'd0},
        '{1'b1, ROT_90, MIR_NONE, 13'd1024, 13'd768, 1'b1, 16'hFFFF, 16'hFFFF,
          1'b1, 1'b1, 12'd1023, 12'd767},
        '{1'b1, ROT_180, MIR_NONE, 13'd1024, 13'd768, 1'b1, 16'd0, 16'd0,
          1'b1, 1'b1, 12'd0, 12'd767},
        '{1'b1, ROT_180, MIR_NONE, 13'd1024, 13'd768, 1'b1, 16'hFFFF, 16'hFFFF,
          1'b1, 1'b1, 12'd1023, 12'd0},
        '{1'b1, ROT_270, MIR_NONE, 13'd1024, 13'd768, 1'b1, 16'd0, 16'd0,
          1'b1, 1'b1, 12'd767, 12'd767},
        '{1'b1, ROT_270, MIR_NONE, 13'd1024, 13'd768, 1'b1, 16'hFFFF, 16'hFFFF,
          1'b1, 1'b1, 12'd0, 12'd0},
        // mirror modes
        '{1'b1, ROT_0, MIR_X, 13'd1024, 13'd768, 1'b1, 16'd0, 16'd0,
          1'b1, 1'b1, 12'd0, 12'd0},
        '{1'b1, ROT_0, MIR_Y, 13'd1024, 13'd768, 1'b1, 16'd0, 16'd0,
          1'b1, 1'b1, 12'd1023, 12'd767},
        '{1'b1, ROT_0, MIR_XY, 13'd1024, 13'd768, 1'b1, 16'hFFFF, 16'hFFFF,
          1'b1, 1'b1, 12'd1023, 12'd0},
        // zero view size acts as one
        '{1'b1, ROT_0, MIR_NONE, 13'd0, 13'd0, 1'b1, 16'd300, 16'd400,
          1'b1, 1'b1, 12'd0, 12'd0},
        '{1'b1, ROT_0, MIR_XY, 13'd0, 13'd0, 1'b1, 16'd0, 16'd0,
          1'b1, 1'b1, 12'd0, 12'd0},
        // oversized view caps at 4096
        '{1'b1, ROT_0, MIR_NONE, 13'h1FFF, 13'h1FFF, 1'b1, 16'hFFFF, 16'd0,
          1'b1, 1'b1, 12'd1023, 12'd4095},
        '{1'b1, ROT_0, MIR_XY, 13'd4096, 13'd4096, 1'b1, 16'd0, 16'hFFFF,
          1'b1, 1'b1, 12'd4095, 12'd4095},
        '{1'b1, ROT_180, MIR_NONE, 13'd1, 13'd1, 1'b1, 16'd5, 16'd5,
          1'b1, 1'b1, 12'd0, 12'd0},
        // mixed settings, checked by the mapper alone
        '{1'b1, ROT_270, MIR_X, 13'd4097, 13'd5000, 1'b1, 16'd1000, 16'd100,
          1'b0, 1'b0, 12'd0, 12'd0},
        '{1'b0, ROT_270, MIR_X, 13'd4097, 13'd5000, 1'b1, 16'd55, 16'd66,
          1'b0, 1'b0, 12'd0, 12'd0},
        '{1'b1, ROT_90, MIR_Y, 13'd1, 13'd4096, 1'b1, 16'd12345, 16'd54321,
          1'b0, 1'b0, 12'd0, 12'd0},
        '{1'b1, ROT_0, MIR_NONE, 13'd1024, 13'd768, 1'b0, 16'hA5C3, 16'h3C5A,
          1'b0, 1'b0, 12'd0, 12'd0}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = 32'd0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic        m_tuser;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = 5'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Mapper copy of the registers and of the held state
    logic        cfg_present = 1'b0;
    logic [1:0]  cfg_rot     = ROT_0;
    logic [1:0]  cfg_mirror  = MIR_NONE;
    logic [12:0] cfg_vw      = 13'd1024;
    logic [12:0] cfg_vh      = 13'd768;
    logic [11:0] held_x      = 12'd0;
    logic [11:0] held_y      = 12'd0;
    logic [15:0] held_rx     = 16'd0;
    logic [15:0] held_ry     = 16'd0;
    logic [31:0] press_total = 32'd0;

    touch_result_t pending_points [$];
    bit            quiet          = 1'b0;
    int            mismatches     = 0;
    int            results_seen   = 0;
    int            presses_seen   = 0;
    int            polls_sent     = 0;
    int            settings_count = 0;
    int            cycle_count    = 0;

    touch_point_rotate_mirror_clamp_core #(
        .PANEL_WIDTH (PANEL_W),
        .PANEL_HEIGHT(PANEL_H)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 aclk = ~aclk;

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("run timed out after %0d cycles", cycle_count);
            $display("[touch_point_rotate_mirror_clamp_core] ERROR");
            $finish;
        end
    end

    // Limit a view size to 1..4096
    function automatic int view_extent(logic [12:0] s);
        if (s == 13'd0) begin
            return 1;
        end
        if (s > 13'd4096) begin
            return 4096;
        end
        return int'(s);
    endfunction

    // Clamp one axis into 0..extent-1
    function automatic logic [11:0] fit_axis(int v, int extent);
        if (v < 0) begin
            return 12'd0;
        end
        if (v >= extent) begin
            return 12'(extent - 1);
        end
        return 12'(v);
    endfunction

    // Map one poll and advance the held state
    function automatic touch_result_t map_poll(logic touched, logic [15:0] rx,
                                               logic [15:0] ry);
        touch_result_t r;
        int w;
        int h;
        int px;
        int py;
        int lx;
        int ly;
        r.pressed = 1'b0;
        if (cfg_present && touched) begin
            w  = view_extent(cfg_vw);
            h  = view_extent(cfg_vh);
            // fixed quarter turn from controller to panel axes
            px = PANEL_W - 1 - int'(ry);
            py = int'(rx);
            lx = px;
            ly = py;
            case (cfg_rot)
                ROT_90: begin
                    lx = py;
                    ly = PANEL_W - 1 - px;
                end
                ROT_180: begin
                    lx = PANEL_W - 1 - px;
                    ly = PANEL_H - 1 - py;
                end
                ROT_270: begin
                    lx = PANEL_H - 1 - py;
                    ly = px;
                end
                default: begin
                end
            endcase
            if (cfg_mirror[MIRROR_X_BIT]) begin
                lx = w - 1 - lx;
            end
            if (cfg_mirror[MIRROR_Y_BIT]) begin
                ly = h - 1 - ly;
            end
            held_x      = fit_axis(lx, w);
            held_y      = fit_axis(ly, h);
            held_rx     = rx;
            held_ry     = ry;
            press_total = press_total + 32'd1;
            r.pressed   = 1'b1;
        end
        r.point_x = held_x;
        r.point_y = held_y;
        r.raw_x   = held_rx;
        r.raw_y   = held_ry;
        r.presses = press_total;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTS) begin
            $display("mismatch at result %0d: %s got 0x%0h, want 0x%0h",
                     results_seen, what, got, want);
        end
    endtask

    // Two-phase register write; update the mapper copy once it lands
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SENSOR_PRESENT: cfg_present = value[0];
            REG_ROTATION:       cfg_rot     = value[1:0];
            REG_FLIP_SEL:       cfg_mirror  = value[1:0];
            REG_VIEW_WIDTH:     cfg_vw      = value[12:0];
            REG_VIEW_HEIGHT:    cfg_vh      = value[12:0];
            default: begin
            end
        endcase
    endtask

    // Drop valid, wait for every pending result, then let the pipe settle
    task automatic drain_points();
        s_tvalid <= 1'b0;
        while (pending_points.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_setting(logic present, logic [1:0] rot, logic [1:0] mirror,
                                 logic [12:0] vw, logic [12:0] vh);
        drain_points();
        write_reg(REG_SENSOR_PRESENT, {31'd0, present});
        write_reg(REG_ROTATION, {30'd0, rot});
        write_reg(REG_FLIP_SEL, {30'd0, mirror});
        write_reg(REG_VIEW_WIDTH, {19'd0, vw});
        write_reg(REG_VIEW_HEIGHT, {19'd0, vh});
        settings_count++;
    endtask

    // Send one poll item; record its expected result on acceptance
    task automatic send_poll(logic touched, logic [15:0] rx, logic [15:0] ry,
                             logic known, logic k_pressed, logic [11:0] k_x,
                             logic [11:0] k_y);
        int gap;
        touch_result_t r;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ry, rx};
        s_tuser  <= touched;
        do @(posedge aclk); while (s_tready !== 1'b1);
        r = map_poll(touched, rx, ry);
        if (known) begin
            r.pressed = k_pressed;
            r.point_x = k_x;
            r.point_y = k_y;
        end
        pending_points.push_back(r);
        polls_sent++;
    endtask

    function automatic logic [15:0] pick_raw();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(0, 1100));
        endcase
    endfunction

    function automatic logic [12:0] pick_view();
        case ($urandom_range(0, 7))
            0:       return 13'd0;
            1:       return 13'd1;
            2:       return 13'd4096;
            3:       return 13'h1FFF;
            4:       return 13'($urandom_range(4097, 8191));
            5:       return 13'($urandom_range(1, 64));
            default: return 13'($urandom_range(1, 4096));
        endcase
    endfunction

    // Take results with random stalls and check each against the oldest expectation
    initial begin
        int stall;
        touch_result_t want;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid === 1'b1 && m_tready) begin
                results_seen++;
                if (m_tuser === 1'b1) begin
                    presses_seen++;
                end
                if (pending_points.size() == 0) begin
                    report_mismatch("result with nothing pending", m_tdata[31:0], 32'd0);
                end else begin
                    want = pending_points.pop_front();
                    if (m_tuser !== want.pressed) begin
                        report_mismatch("pressed", 32'(m_tuser), 32'(want.pressed));
                    end
                    if (m_tdata[11:0] !== want.point_x) begin
                        report_mismatch("point_x", 32'(m_tdata[11:0]), 32'(want.point_x));
                    end
                    if (m_tdata[23:12] !== want.point_y) begin
                        report_mismatch("point_y", 32'(m_tdata[23:12]), 32'(want.point_y));
                    end
                    if (m_tdata[39:24] !== want.raw_x) begin
                        report_mismatch("held_raw_x", 32'(m_tdata[39:24]), 32'(want.raw_x));
                    end
                    if (m_tdata[55:40] !== want.raw_y) begin
                        report_mismatch("held_raw_y", 32'(m_tdata[55:40]), 32'(want.raw_y));
                    end
                    if (m_tdata[87:56] !== want.presses) begin
                        report_mismatch("press_count", m_tdata[87:56], want.presses);
                    end
                end
                stall = quiet ? 0 : $urandom_range(0, 3);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Reset, directed polls, random phases, wind-down
    initial begin
        poll_row_t row;
        int        waited;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_COUNT; i++) begin
            row = DIR_ROWS[i];
            if ({row.present, row.rot, row.mirror, row.vw, row.vh} !=
                {cfg_present, cfg_rot, cfg_mirror, cfg_vw, cfg_vh}) begin
                apply_setting(row.present, row.rot, row.mirror, row.vw, row.vh);
            end
            send_poll(row.touched, row.rx, row.ry, row.known, row.k_pressed,
                      row.k_x, row.k_y);
        end

        // Random settings, one per phase; some phases run without idling
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            apply_setting($urandom_range(0, 7) != 0, 2'($urandom_range(0, 3)),
                          2'($urandom_range(0, 3)), pick_view(), pick_view());
            quiet = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_poll($urandom_range(0, 3) != 0, pick_raw(), pick_raw(),
                          1'b0, 1'b0, 12'd0, 12'd0);
            end
            quiet = 1'b0;
        end

        // Wait out the remaining results
        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_points.size() != 0 && waited < END_WAIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (END_CYCLES) @(posedge aclk);
        if (pending_points.size() != 0) begin
            report_mismatch("results never arrived", pending_points.size(), 32'd0);
        end

        $display("sent %0d polls under %0d register settings; %0d results, %0d presses",
                 polls_sent, settings_count, results_seen, presses_seen);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0) begin
            $display("[touch_point_rotate_mirror_clamp_core] OK");
        end else begin
            $display("[touch_point_rotate_mirror_clamp_core] ERROR");
        end
        $finish;
    end

endmodule
